FILE: hdl/assert_macros.svh
// Assertion macros used by the checker file rmmv_checker.sv.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("%m: assertion failed");

// Property checked on every clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("%m: assertion failed");

`endif

FILE: hdl/rmmv_pkg.sv
// Shared constants, types and codes of the region mean motion vector block.
// No dependencies.
package rmmv_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 2048;
  localparam int FLOW_BITS  = 16;
  localparam int FRAC_BITS  = 6;

  localparam int COL_BITS   = $clog2(MAX_WIDTH);
  localparam int ROW_BITS   = $clog2(MAX_HEIGHT);
  localparam int WIDTH_BITS = COL_BITS + 1;

  localparam int COUNT_BITS = 23;
  localparam int SUM_BITS   = FLOW_BITS + COUNT_BITS;
  localparam int DIV_BITS   = SUM_BITS - FRAC_BITS;
  localparam int MEAN_BITS  = 10;
  localparam int STEP_BITS  = $clog2(MEAN_BITS);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 12;

  localparam int S_TDATA_BITS = ((2 * FLOW_BITS + 7) / 8) * 8;
  localparam int OUT_BITS     = 2 * MEAN_BITS + COUNT_BITS;
  localparam int M_TDATA_BITS = ((OUT_BITS + 7) / 8) * 8;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QFILL_BITS  = $clog2(QUEUE_DEPTH + 1);

  localparam logic [WIDTH_BITS-1:0] RESET_FRAME_WIDTH = WIDTH_BITS'(640);
  localparam logic [WIDTH_BITS-1:0] RESET_RECT_RIGHT  = WIDTH_BITS'(MAX_WIDTH);
  localparam logic [ROW_BITS:0]     RESET_RECT_BOTTOM = (ROW_BITS + 1)'(MAX_HEIGHT);

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_FRAME_WIDTH,
    REG_RECT_LEFT,
    REG_RECT_TOP,
    REG_RECT_RIGHT,
    REG_RECT_BOTTOM
  } cfg_reg_t;

  typedef struct packed {
    logic signed [SUM_BITS-1:0]   sum_x;
    logic signed [SUM_BITS-1:0]   sum_y;
    logic        [COUNT_BITS-1:0] count;
  } frame_sum_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_DIV,
    B_HOLD
  } back_state_t;

endpackage

FILE: hdl/rmmv_front.sv
// Front end: configuration registers, raster counters, region test and sums.
// Depends on rmmv_pkg; pushes one frame_sum_t per frame into the queue.
module rmmv_front import rmmv_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [S_TDATA_BITS-1:0]   s_tdata,
  input  logic                      s_tlast,
  input  logic                      q_full,
  output logic                      push,
  output frame_sum_t                push_data
);

  logic [WIDTH_BITS-1:0] frame_width;
  logic [COL_BITS-1:0]   rect_left;
  logic [ROW_BITS-1:0]   rect_top;
  logic [WIDTH_BITS-1:0] rect_right;
  logic [ROW_BITS:0]     rect_bottom;

  logic [COL_BITS-1:0]        col, col_next;
  logic [ROW_BITS-1:0]        row, row_next;
  logic signed [SUM_BITS-1:0] sum_x, sum_x_next;
  logic signed [SUM_BITS-1:0] sum_y, sum_y_next;
  logic [COUNT_BITS-1:0]      count, count_next;

  logic [WIDTH_BITS-1:0]       width_eff;
  logic [WIDTH_BITS-1:0]       col_inc;
  logic [ROW_BITS:0]           row_inc;
  logic signed [FLOW_BITS-1:0] mx, my;
  logic                        in_region, add, accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width <= RESET_FRAME_WIDTH;
      rect_left   <= '0;
      rect_top    <= '0;
      rect_right  <= RESET_RECT_RIGHT;
      rect_bottom <= RESET_RECT_BOTTOM;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_FRAME_WIDTH: frame_width <= cfg_data[WIDTH_BITS-1:0];
        REG_RECT_LEFT:   rect_left   <= cfg_data[COL_BITS-1:0];
        REG_RECT_TOP:    rect_top    <= cfg_data[ROW_BITS-1:0];
        REG_RECT_RIGHT:  rect_right  <= cfg_data[WIDTH_BITS-1:0];
        REG_RECT_BOTTOM: rect_bottom <= cfg_data[ROW_BITS:0];
        default: ;
      endcase
    end
  end

  assign mx       = s_tdata[FLOW_BITS-1:0];
  assign my       = s_tdata[2*FLOW_BITS-1:FLOW_BITS];
  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    // clamp the programmed width into 1..MAX_WIDTH
    if (frame_width == '0) begin
      width_eff = WIDTH_BITS'(1);
    end else if (frame_width > WIDTH_BITS'(MAX_WIDTH)) begin
      width_eff = WIDTH_BITS'(MAX_WIDTH);
    end else begin
      width_eff = frame_width;
    end

    in_region = (col >= rect_left) && ({1'b0, col} < rect_right) &&
                (row >= rect_top) && ({1'b0, row} < rect_bottom);
    add = in_region && (mx != '0 || my != '0) && (count != COUNT_MAX);

    sum_x_next = add ? sum_x + SUM_BITS'(mx) : sum_x;
    sum_y_next = add ? sum_y + SUM_BITS'(my) : sum_y;
    count_next = add ? count + COUNT_BITS'(1) : count;

    col_inc = {1'b0, col} + WIDTH_BITS'(1);
    row_inc = {1'b0, row} + (ROW_BITS + 1)'(1);
    if (col_inc >= width_eff) begin
      col_next = '0;
      row_next = (row_inc >= (ROW_BITS + 1)'(MAX_HEIGHT)) ? '0 : row_inc[ROW_BITS-1:0];
    end else begin
      col_next = col_inc[COL_BITS-1:0];
      row_next = row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col   <= '0;
      row   <= '0;
      sum_x <= '0;
      sum_y <= '0;
      count <= '0;
    end else if (accept) begin
      if (s_tlast) begin
        // frame handed to the queue: start the next one clean
        col   <= '0;
        row   <= '0;
        sum_x <= '0;
        sum_y <= '0;
        count <= '0;
      end else begin
        col   <= col_next;
        row   <= row_next;
        sum_x <= sum_x_next;
        sum_y <= sum_y_next;
        count <= count_next;
      end
    end
  end

  assign push            = accept && s_tlast;
  assign push_data.sum_x = sum_x_next;
  assign push_data.sum_y = sum_y_next;
  assign push_data.count = count_next;

endmodule

FILE: hdl/rmmv_queue.sv
// Short queue of finished frame sums between front end and divider.
// Depends on rmmv_pkg.
module rmmv_queue import rmmv_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  frame_sum_t push_data,
  output logic       full,
  input  logic       pop,
  output logic       valid,
  output frame_sum_t head
);

  frame_sum_t            entries [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0]  wr_ptr, rd_ptr;
  logic [QFILL_BITS-1:0] fill;

  assign full  = (fill == QFILL_BITS'(QUEUE_DEPTH));
  assign valid = (fill != '0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_BITS'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_BITS'(1);
      end
      if (push && !pop) begin
        fill <= fill + QFILL_BITS'(1);
      end else if (pop && !push) begin
        fill <= fill - QFILL_BITS'(1);
      end
    end
  end

endmodule

FILE: hdl/rmmv_back.sv
// Back end: restoring divider for both means and the result register.
// Depends on rmmv_pkg; pops one frame_sum_t per result.
module rmmv_back import rmmv_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    q_valid,
  input  frame_sum_t              q_head,
  output logic                    pop,
  output logic                    m_tvalid,
  input  logic                    m_tready,
  output logic [M_TDATA_BITS-1:0] m_tdata
);

  back_state_t state, state_next;

  logic [STEP_BITS-1:0]  step;
  logic                  neg_x, neg_y;
  logic [DIV_BITS-1:0]   rem_x, rem_y;
  logic [MEAN_BITS-1:0]  quo_x, quo_y;
  logic [COUNT_BITS-1:0] divisor;

  logic [SUM_BITS-1:0]   mag_x, mag_y;
  logic [DIV_BITS-1:0]   trial;
  logic                  fit_x, fit_y;
  logic                  div_en, load_out;
  logic [MEAN_BITS-1:0]  mean_x, mean_y;

  logic                  out_valid;
  logic [MEAN_BITS-1:0]  out_mean_x, out_mean_y;
  logic [COUNT_BITS-1:0] out_count;

  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE: if (q_valid) state_next = B_DIV;
      B_DIV:  if (step == '0) state_next = B_HOLD;
      B_HOLD: if (!out_valid || m_tready) state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  always_comb begin
    pop      = (state == B_IDLE) && q_valid;
    div_en   = (state == B_DIV);
    load_out = (state == B_HOLD) && (!out_valid || m_tready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // sum / (count * 64) equals (|sum| >> 6) / count, so drop the fraction first
  assign mag_x = q_head.sum_x[SUM_BITS-1] ? SUM_BITS'(-q_head.sum_x) : SUM_BITS'(q_head.sum_x);
  assign mag_y = q_head.sum_y[SUM_BITS-1] ? SUM_BITS'(-q_head.sum_y) : SUM_BITS'(q_head.sum_y);

  assign trial = DIV_BITS'(divisor) << step;
  assign fit_x = (rem_x >= trial);
  assign fit_y = (rem_y >= trial);

  always_ff @(posedge clk) begin
    if (pop) begin
      neg_x   <= q_head.sum_x[SUM_BITS-1];
      neg_y   <= q_head.sum_y[SUM_BITS-1];
      rem_x   <= mag_x[SUM_BITS-1:FRAC_BITS];
      rem_y   <= mag_y[SUM_BITS-1:FRAC_BITS];
      quo_x   <= '0;
      quo_y   <= '0;
      divisor <= q_head.count;
      step    <= STEP_BITS'(MEAN_BITS - 1);
    end else if (div_en) begin
      if (fit_x) rem_x <= rem_x - trial;
      if (fit_y) rem_y <= rem_y - trial;
      quo_x <= {quo_x[MEAN_BITS-2:0], fit_x};
      quo_y <= {quo_y[MEAN_BITS-2:0], fit_y};
      if (step != '0) step <= step - STEP_BITS'(1);
    end
  end

  always_comb begin
    if (divisor == '0) begin
      mean_x = '0;
      mean_y = '0;
    end else begin
      mean_x = neg_x ? MEAN_BITS'(-quo_x) : quo_x;
      mean_y = neg_y ? MEAN_BITS'(-quo_y) : quo_y;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_mean_x <= mean_x;
      out_mean_y <= mean_y;
      out_count  <= divisor;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {{(M_TDATA_BITS - OUT_BITS){1'b0}}, out_count, out_mean_y, out_mean_x};

endmodule

FILE: hdl/region_mean_motion_vector.sv
// Region mean of a motion-vector stream: one vector per beat in, one mean per frame out.
// The end-of-frame sums pass through the queue, the divider and the result register.
// Throughput: one vector per cycle while s_tready is high; the 10-step divider takes one
// frame at a time, and s_tready drops only when the two-frame queue in front of it is full.
// Reset (rst, synchronous): registers to defaults, counters and sums cleared, queue empty.
// Depends on rmmv_pkg, rmmv_front, rmmv_queue, rmmv_back.
module region_mean_motion_vector import rmmv_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [S_TDATA_BITS-1:0]   s_tdata,   // motion_x, motion_y
  input  logic                      s_tlast,   // end_of_frame
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [M_TDATA_BITS-1:0]   m_tdata    // mean_x, mean_y, moving_count, zero pad
);

  logic       q_full, q_valid, push, pop;
  frame_sum_t push_data, q_head;

  rmmv_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  rmmv_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .valid     (q_valid),
    .head      (q_head)
  );

  rmmv_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_head   (q_head),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

FILE: hdl/rmmv_checker.sv
// Port-level checks of the region mean block, bound to the top level.
// Depends on rmmv_pkg and assert_macros.svh.
`include "assert_macros.svh"

module rmmv_checker import rmmv_pkg::*; (
  input logic                      clk,
  input logic                      rst,
  input logic                      s_tvalid,
  input logic                      s_tready,
  input logic                      s_tlast,
  input logic                      m_tvalid,
  input logic                      m_tready,
  input logic [M_TDATA_BITS-1:0]   m_tdata
);

  logic [2:0] pending;
  logic       frame_in, result_out, empty_frame;

  assign frame_in    = s_tvalid && s_tready && s_tlast;
  assign result_out  = m_tvalid && m_tready;
  assign empty_frame = (m_tdata[OUT_BITS-1:2*MEAN_BITS] == '0);

  // frames closed on the input side but not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if (frame_in && !result_out) begin
      pending <= pending + 3'd1;
    end else if (result_out && !frame_in) begin
      pending <= pending - 3'd1;
    end
  end

  `ASSERT_CLK(a_out_hold, clk, rst, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
  `ASSERT_ALWAYS(a_reset_quiet, clk, $past(rst) |-> !m_tvalid)
  `ASSERT_CLK(a_result_needs_frame, clk, rst, m_tvalid |-> pending != 3'd0)
  `ASSERT_CLK(a_empty_mean_zero, clk, rst, m_tvalid && empty_frame |-> m_tdata[2*MEAN_BITS-1:0] == '0)

endmodule

bind region_mean_motion_vector rmmv_checker u_checker (.*);
